@@ hw/rtl/bsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared types and constants of the 4x4 block-sum downsampler.
// ----------------------------------------------------------------------------
package bsd_pkg;

    localparam int MAX_BLOCK_COLS_DEF = 256;
    localparam int BLOCK_ROWS_MAX     = 4096;
    localparam int BLOCK_SIZE         = 4;
    localparam int SUB_W              = 2;

    localparam int PIXEL_W      = 8;
    localparam int VALUE_W      = 8;
    localparam int USED_W       = 21;
    localparam int SUM_W        = 12;
    localparam int COLS_W       = 9;
    localparam int ROWS_W       = 13;
    localparam int ROW_CNT_W    = 14;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 13;

    localparam logic [USED_W-1:0] USED_MAX = '1;

    typedef logic [PIXEL_W-1:0] pixel_t;
    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [USED_W-1:0]  used_t;
    typedef logic [SUM_W-1:0]   sum_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_COLS = 1'b0,
        REG_BLOCK_ROWS = 1'b1
    } cfg_reg_t;

endpackage

@@ hw/rtl/bsd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_if
// Valid/ready channels of the downsampler: pixel words in, block words out.
// ----------------------------------------------------------------------------
interface bsd_pixel_if;
    import bsd_pkg::*;

    logic   valid;
    logic   ready;
    pixel_t pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface bsd_block_if;
    import bsd_pkg::*;

    logic   valid;
    logic   ready;
    value_t block_value;
    used_t  used_count;
    logic   last;

    modport source (output valid, output block_value, output used_count, output last,
                    input ready);
    modport sink   (input valid, input block_value, input used_count, input last,
                    output ready);
endinterface

@@ hw/rtl/block_sum_downsample_4x4.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_sum_downsample_4x4
// 4x4 box-sum downsampler with a line store of per-block-column partial sums.
// ----------------------------------------------------------------------------
// Throughput: one pixel word per cycle while the output is not blocked, set by
//   the line store doing one read and one write per pixel on its two ports.
// Path: an accepted closing pixel is registered in stage 1 with its line store
//   read, then its sum goes into the output register once the output is free.
// Reset: counters, used count and sizes (1x1 blocks) clear at once; the line
//   store is not cleared, the first row of each block row overwrites it.
module block_sum_downsample_4x4 #(
    parameter int MAX_BLOCK_COLS = bsd_pkg::MAX_BLOCK_COLS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bsd_pkg::CFG_DATA_W-1:0] cfg_data,
    bsd_pixel_if.sink                      pixels,
    bsd_block_if.source                    blocks
);
    import bsd_pkg::*;

    localparam int COL_W = $clog2(BLOCK_SIZE * MAX_BLOCK_COLS);
    localparam int CNT_W = COL_W + 1;
    localparam int AW    = (MAX_BLOCK_COLS > 1) ? $clog2(MAX_BLOCK_COLS) : 1;
    localparam int HT_W  = ROW_CNT_W + 1;

    // configuration
    logic [COLS_W-1:0] block_cols_reg;
    logic [ROWS_W-1:0] block_rows_reg;

    // position counters
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_CNT_W-1:0] row_reg, row_next;

    // stage 1: line store data arrives
    logic          s1_valid_reg, s1_valid_next;
    pixel_t        s1_pix_reg;
    logic          s1_subx0_reg;
    logic          s1_first_reg;
    logic          s1_closes_reg;
    logic          s1_frame_end_reg;
    logic [AW-1:0] s1_slot_reg;
    logic          fwd_hit_reg;
    sum_t          fwd_data_reg;
    sum_t          acc_reg;
    used_t         used_reg, used_next;

    // output register
    logic   out_valid_reg, out_valid_next;
    value_t out_value_reg;
    used_t  out_used_reg;
    logic   out_last_reg;

    logic [CNT_W-1:0] width_px;
    logic [HT_W-1:0]  height_px;
    logic             col_wrap;
    logic             row_wrap;
    logic             accept;
    logic             s1_go;
    logic [AW-1:0]    slot;
    logic [SUB_W-1:0] subx;
    logic [SUB_W-1:0] suby;
    logic             frame_end;
    sum_t             ram_rdata;
    sum_t             base;
    sum_t             sum;
    used_t            used_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_cols_reg <= COLS_W'(1);
            block_rows_reg <= ROWS_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BLOCK_COLS: block_cols_reg <= cfg_data[COLS_W-1:0];
                REG_BLOCK_ROWS: block_rows_reg <= cfg_data[ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp sizes: zero acts as one block, oversize as the maximum
    always_comb
    begin
        if (block_cols_reg == '0)
            width_px = CNT_W'(BLOCK_SIZE);
        else if (32'(block_cols_reg) > 32'(MAX_BLOCK_COLS))
            width_px = CNT_W'(MAX_BLOCK_COLS * BLOCK_SIZE);
        else
            width_px = CNT_W'({block_cols_reg, 2'b00});

        if (block_rows_reg == '0)
            height_px = HT_W'(BLOCK_SIZE);
        else if (32'(block_rows_reg) > 32'(BLOCK_ROWS_MAX))
            height_px = HT_W'(BLOCK_ROWS_MAX * BLOCK_SIZE);
        else
            height_px = HT_W'({block_rows_reg, 2'b00});
    end

    assign col_wrap  = ({1'b0, col_reg} + CNT_W'(1)) >= width_px;
    assign row_wrap  = ({1'b0, row_reg} + HT_W'(1)) >= height_px;
    assign frame_end = col_wrap && row_wrap;
    assign subx      = col_reg[SUB_W-1:0];
    assign suby      = row_reg[SUB_W-1:0];
    assign slot      = AW'(col_reg >> SUB_W);

    // stage 1 retires unless it holds a block word and the output is blocked
    assign s1_go  = s1_valid_reg && (!s1_closes_reg || !out_valid_reg || blocks.ready);
    assign accept = pixels.valid && pixels.ready;
    assign pixels.ready = !s1_valid_reg || s1_go;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + ROW_CNT_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    bsd_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_BLOCK_COLS)
    ) u_line_store (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_slot_reg),
        .wdata (sum),
        .re    (accept),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    // within a block row the running sum comes from the previous pixel;
    // at a block's left edge it comes from the line store, and at its top-left pixel it is zero
    always_comb
    begin
        if (s1_first_reg)
            base = '0;
        else if (!s1_subx0_reg)
            base = acc_reg;
        else if (fwd_hit_reg)
            base = fwd_data_reg;
        else
            base = ram_rdata;
        sum = base + SUM_W'(s1_pix_reg);
    end

    assign used_inc = (sum != '0 && used_reg != USED_MAX) ? used_reg + USED_W'(1) : used_reg;

    always_comb
    begin
        used_next = used_reg;
        if (s1_go)
        begin
            if (s1_frame_end_reg)
                used_next = '0;
            else if (s1_closes_reg)
                used_next = used_inc;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_go && s1_closes_reg)
            out_valid_next = 1'b1;
        else if (blocks.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            s1_valid_reg  <= s1_valid_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg       <= pixels.pixel;
            s1_subx0_reg     <= (subx == '0);
            s1_first_reg     <= (subx == '0) && (suby == '0);
            s1_closes_reg    <= (subx == SUB_W'(BLOCK_SIZE - 1))
                                && (suby == SUB_W'(BLOCK_SIZE - 1));
            s1_frame_end_reg <= frame_end;
            s1_slot_reg      <= slot;
            // forward the write that lands in the same cycle as this read
            fwd_hit_reg      <= s1_go && (s1_slot_reg == slot);
            fwd_data_reg     <= sum;
        end
        if (s1_go)
        begin
            acc_reg <= sum;
        end
        if (s1_go && s1_closes_reg)
        begin
            out_value_reg <= sum[VALUE_W-1:0];
            out_used_reg  <= used_inc;
            out_last_reg  <= s1_frame_end_reg;
        end
    end

    assign blocks.valid       = out_valid_reg;
    assign blocks.block_value = out_value_reg;
    assign blocks.used_count  = out_used_reg;
    assign blocks.last        = out_last_reg;

endmodule

@@ hw/rtl/bsd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bsd_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 256
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read returns the old word on a same-address write
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/bsd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_checker
// Port-level assertions of the downsampler, bound to the top level.
// ----------------------------------------------------------------------------
module bsd_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [bsd_pkg::VALUE_W-1:0] block_value,
    input logic [bsd_pkg::USED_W-1:0]  used_count,
    input logic                   last
);
    import bsd_pkg::*;

    logic  seen_reg;
    logic  prev_last_reg;
    used_t prev_used_reg;
    logic  out_accept;

    assign out_accept = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            prev_last_reg <= 1'b0;
            prev_used_reg <= '0;
        end
        else if (out_accept)
        begin
            seen_reg      <= 1'b1;
            prev_last_reg <= last;
            prev_used_reg <= used_count;
        end
    end

    // a stalled block word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(block_value)
            && $stable(used_count) && $stable(last))
        else $error("block word changed while stalled");

    // input backpressure only comes from a blocked output
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("pixel input stalled without output backpressure");

    // a nonzero block value implies the block itself was counted
    a_used_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && block_value != '0 |-> used_count != '0)
        else $error("nonzero block not counted");

    // the used count steps by zero or one, or restarts when a shortened
    // frame ends on a pixel that closes no block
    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_accept && seen_reg && !prev_last_reg
            |-> used_count == prev_used_reg || used_count == prev_used_reg + USED_W'(1)
                || used_count <= USED_W'(1))
        else $error("used count jumped within a frame");

    // the first block of a frame counts at most itself
    a_used_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_accept && (!seen_reg || prev_last_reg) |-> used_count <= USED_W'(1))
        else $error("used count did not restart at frame start");

endmodule

bind block_sum_downsample_4x4 bsd_checker u_bsd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (pixels.ready),
    .out_valid   (blocks.valid),
    .out_ready   (blocks.ready),
    .block_value (blocks.block_value),
    .used_count  (blocks.used_count),
    .last        (blocks.last)
);
